@@ hw/rtl/tlap_pkg.sv @@
package tlap_pkg;

  localparam int COORD_W    = 16;
  localparam int COORD_BITS = 16;
  localparam int BYTE_W     = 8;
  localparam int ADDR_W     = 32;
  localparam int TEXEL_W    = 32;
  localparam int WIDTH_W    = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int MODE_W     = 2;
  localparam int CHAN_W     = 3;

  localparam logic [COORD_W-1:0] COORD_MASK =
    COORD_W'((33'd1 << COORD_BITS) - 33'd1);

  localparam logic [MODE_W-1:0] LAYOUT_LINEAR   = 2'd0;
  localparam logic [MODE_W-1:0] LAYOUT_TILE4    = 2'd1;
  localparam logic [MODE_W-1:0] LAYOUT_MORTON32 = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_LAYOUT_MODE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT = 2'd2;

  localparam logic [CHAN_W-1:0] CHAN_RGB  = 3'd3;
  localparam logic [CHAN_W-1:0] CHAN_RGBA = 3'd4;

  localparam logic [BYTE_W-1:0] ALPHA_OPAQUE = 8'hFF;

  localparam int TILE4_SHIFT  = 2;
  localparam int TILE32_SHIFT = 5;
  localparam int TILE4_AREA_SHIFT  = 2 * TILE4_SHIFT;
  localparam int TILE32_AREA_SHIFT = 2 * TILE32_SHIFT;

endpackage

@@ hw/rtl/tlap_if.sv @@
interface tlap_in_if;
  import tlap_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [COORD_W-1:0]   pos_x;
  logic [COORD_W-1:0]   pos_y;
  logic [BYTE_W-1:0]    src_byte0;
  logic [BYTE_W-1:0]    src_byte1;
  logic [BYTE_W-1:0]    src_byte2;
  logic [BYTE_W-1:0]    src_byte3;

  modport source (output valid, pos_x, pos_y, src_byte0, src_byte1, src_byte2, src_byte3,
                  input ready);
  modport sink   (input valid, pos_x, pos_y, src_byte0, src_byte1, src_byte2, src_byte3,
                  output ready);
endinterface

interface tlap_out_if;
  import tlap_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [ADDR_W-1:0]    word_address;
  logic [TEXEL_W-1:0]   packed_texel;

  modport source (output valid, word_address, packed_texel, input ready);
  modport sink   (input valid, word_address, packed_texel, output ready);
endinterface

@@ hw/rtl/texel_layout_address_and_pack.sv @@
// Three register stages (operand select, multiply, add/pack); each input transfer
// passes through them in that order before its result is offered on out_ch.
// Throughput: one texel per cycle; the whole pipeline advances when the output
// register is empty or its result is taken, so a stall freezes every stage.
// Reset (synchronous, rst_n low): all stage valid bits clear; registers return to
// linear layout, width 1, four channels.
module texel_layout_address_and_pack
  import tlap_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  tlap_in_if.sink               in_ch,
  tlap_out_if.source            out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic [MODE_W-1:0]  mode_r;
  logic [WIDTH_W-1:0] width_r;
  logic [CHAN_W-1:0]  chan_r;

  logic               advance;

  // stage 1
  logic               v1_r;
  logic [COORD_W-1:0] mul_a_r, mul_a_nxt;
  logic [WIDTH_W-1:0] mul_b_r, mul_b_nxt;
  logic [COORD_W-1:0] xadd_r, xadd_nxt;
  logic [TILE32_AREA_SHIFT-1:0] ofs_r, ofs_nxt;
  logic [MODE_W-1:0]  lmode1_r, lmode_nxt;
  logic [TEXEL_W-1:0] texel1_r, texel_nxt;

  // stage 2
  logic               v2_r;
  logic [ADDR_W-1:0]  prod_r;
  logic [COORD_W-1:0] xadd2_r;
  logic [TILE32_AREA_SHIFT-1:0] ofs2_r;
  logic [MODE_W-1:0]  lmode2_r;
  logic [TEXEL_W-1:0] texel2_r;

  // stage 3 / output
  logic               v3_r;
  logic [ADDR_W-1:0]  addr_r, addr_nxt;
  logic [TEXEL_W-1:0] texel3_r;

  logic [COORD_W-1:0] x_in, y_in;
  logic [WIDTH_W:0]   tiles4_sum, tiles32_sum;
  logic [ADDR_W-1:0]  row_sum;

  function automatic logic [TILE32_AREA_SHIFT-1:0] morton5(
    input logic [TILE32_SHIFT-1:0] tx,
    input logic [TILE32_SHIFT-1:0] ty
  );
    logic [TILE32_AREA_SHIFT-1:0] code;
    code = '0;
    for (int i = 0; i < TILE32_SHIFT; i++) begin
      code[2*i]   = tx[i];
      code[2*i+1] = ty[i];
    end
    return code;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= LAYOUT_LINEAR;
      width_r <= WIDTH_W'(1);
      chan_r  <= CHAN_RGBA;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_LAYOUT_MODE:   mode_r  <= cfg_wdata[MODE_W-1:0];
        CFG_IMAGE_WIDTH:   width_r <= cfg_wdata[WIDTH_W-1:0];
        CFG_CHANNEL_COUNT: chan_r  <= cfg_wdata[CHAN_W-1:0];
        default: ;
      endcase
    end
  end

  assign advance     = !v3_r || out_ch.ready;
  assign in_ch.ready = advance;

  assign x_in        = in_ch.pos_x & COORD_MASK;
  assign y_in        = in_ch.pos_y & COORD_MASK;
  assign tiles4_sum  = {1'b0, width_r} + (WIDTH_W+1)'(3);
  assign tiles32_sum = {1'b0, width_r} + (WIDTH_W+1)'(31);

  always_comb begin
    lmode_nxt = mode_r;
    unique case (mode_r)
      LAYOUT_TILE4: begin
        mul_a_nxt = y_in >> TILE4_SHIFT;
        mul_b_nxt = WIDTH_W'(tiles4_sum >> TILE4_SHIFT);
        xadd_nxt  = x_in >> TILE4_SHIFT;
        ofs_nxt   = TILE32_AREA_SHIFT'({y_in[TILE4_SHIFT-1:0], x_in[TILE4_SHIFT-1:0]});
      end
      LAYOUT_MORTON32: begin
        mul_a_nxt = y_in >> TILE32_SHIFT;
        mul_b_nxt = WIDTH_W'(tiles32_sum >> TILE32_SHIFT);
        xadd_nxt  = x_in >> TILE32_SHIFT;
        ofs_nxt   = morton5(x_in[TILE32_SHIFT-1:0], y_in[TILE32_SHIFT-1:0]);
      end
      default: begin
        lmode_nxt = LAYOUT_LINEAR;
        mul_a_nxt = y_in;
        mul_b_nxt = width_r;
        xadd_nxt  = x_in;
        ofs_nxt   = '0;
      end
    endcase
  end

  always_comb begin
    unique case (chan_r)
      CHAN_RGB:  texel_nxt = {in_ch.src_byte0, in_ch.src_byte1, in_ch.src_byte2, ALPHA_OPAQUE};
      CHAN_RGBA: texel_nxt = {in_ch.src_byte0, in_ch.src_byte1, in_ch.src_byte2,
                              in_ch.src_byte3};
      default:   texel_nxt = {in_ch.src_byte0, in_ch.src_byte0, in_ch.src_byte0, ALPHA_OPAQUE};
    endcase
  end

  assign row_sum = prod_r + ADDR_W'(xadd2_r);

  always_comb begin
    unique case (lmode2_r)
      LAYOUT_TILE4:    addr_nxt = (row_sum << TILE4_AREA_SHIFT) + ADDR_W'(ofs2_r);
      LAYOUT_MORTON32: addr_nxt = (row_sum << TILE32_AREA_SHIFT) + ADDR_W'(ofs2_r);
      default:         addr_nxt = row_sum;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (advance) begin
      v1_r <= in_ch.valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      mul_a_r  <= mul_a_nxt;
      mul_b_r  <= mul_b_nxt;
      xadd_r   <= xadd_nxt;
      ofs_r    <= ofs_nxt;
      lmode1_r <= lmode_nxt;
      texel1_r <= texel_nxt;

      prod_r   <= ADDR_W'(mul_a_r) * ADDR_W'(mul_b_r);
      xadd2_r  <= xadd_r;
      ofs2_r   <= ofs_r;
      lmode2_r <= lmode1_r;
      texel2_r <= texel1_r;

      addr_r   <= addr_nxt;
      texel3_r <= texel2_r;
    end
  end

  assign out_ch.valid        = v3_r;
  assign out_ch.word_address = addr_r;
  assign out_ch.packed_texel = texel3_r;

  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !v1_r && !v2_r && !v3_r)
    else $error("pipeline valid bits not cleared by reset");

  a_linear_operand: assert property (@(posedge clk) disable iff (!rst_n)
    v1_r && lmode1_r == LAYOUT_LINEAR |-> mul_b_r == width_r && ofs_r == '0)
    else $error("linear layout operands wrong");

  a_alpha_opaque: assert property (@(posedge clk) disable iff (!rst_n)
    v1_r && chan_r != CHAN_RGBA |-> texel1_r[BYTE_W-1:0] == ALPHA_OPAQUE)
    else $error("alpha not opaque for non-RGBA channel count");

  a_tile4_offset: assert property (@(posedge clk) disable iff (!rst_n)
    v2_r && advance && lmode2_r == LAYOUT_TILE4
      |=> addr_r[TILE4_AREA_SHIFT-1:0] == $past(ofs2_r[TILE4_AREA_SHIFT-1:0]))
    else $error("4x4 tile in-tile offset lost");

endmodule
